### hdl/m68ea_pkg.sv
// Shared types, codes and constants for the 68020 effective address unit.
`default_nettype none

package m68ea_pkg;

  // Address bits kept on the result ports
  localparam int ADDR_WIDTH = 32;
  localparam logic [31:0] ADDR_MASK = 32'((64'd1 << ADDR_WIDTH) - 64'd1);

  typedef enum logic [1:0] {
    ACT_WRITE = 2'd0,
    ACT_BEGIN = 2'd1,
    ACT_WORD  = 2'd2,
    ACT_LONG  = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    K_WRITE = 3'd0,
    K_WORD  = 3'd1,
    K_LONG  = 3'd2,
    K_READY = 3'd3,
    K_ERROR = 3'd4
  } kind_t;

  typedef enum logic [3:0] {
    PH_IDLE  = 4'd0,
    PH_D_W   = 4'd1,
    PH_D_HI  = 4'd2,
    PH_D_LO  = 4'd3,
    PH_EXT   = 4'd4,
    PH_BD_W  = 4'd5,
    PH_BD_HI = 4'd6,
    PH_BD_LO = 4'd7,
    PH_IND   = 4'd8,
    PH_OD_W  = 4'd9,
    PH_OD_HI = 4'd10,
    PH_OD_LO = 4'd11
  } phase_t;

  // EA mode field codes
  localparam logic [2:0] MODE_AN_IND  = 3'd2;
  localparam logic [2:0] MODE_POSTINC = 3'd3;
  localparam logic [2:0] MODE_PREDEC  = 3'd4;
  localparam logic [2:0] MODE_DISP    = 3'd5;
  localparam logic [2:0] MODE_INDEX   = 3'd6;
  localparam logic [2:0] MODE_SPECIAL = 3'd7;

  // Register field codes under the special mode
  localparam logic [2:0] SPC_ABS_W    = 3'd0;
  localparam logic [2:0] SPC_ABS_L    = 3'd1;
  localparam logic [2:0] SPC_PC_DISP  = 3'd2;
  localparam logic [2:0] SPC_PC_INDEX = 3'd3;

  // Operand size codes
  localparam logic [2:0] SZ_BYTE = 3'd0;
  localparam logic [2:0] SZ_WORD = 3'd1;
  localparam logic [2:0] SZ_LONG = 3'd2;
  localparam logic [2:0] SZ_QUAD = 3'd3;

  // Displacement size codes of the full extension word
  localparam logic [1:0] DSZ_RSVD = 2'd0;
  localparam logic [1:0] DSZ_NULL = 2'd1;
  localparam logic [1:0] DSZ_WORD = 2'd2;
  localparam logic [1:0] DSZ_LONG = 2'd3;

  localparam logic [2:0] SP_REG = 3'd7;

  typedef struct packed {
    action_t     action;
    logic [3:0]  reg_select;
    logic [31:0] data;
    logic [15:0] word;
    logic [2:0]  mode;
    logic [2:0]  reg_req;
    logic [2:0]  size;
    logic [31:0] pc;
  } req_t;

  typedef struct packed {
    kind_t       kind;
    logic [31:0] address;
    logic [31:0] pc_out;
  } rsp_t;

  // Register file write port
  typedef struct packed {
    logic        en;
    logic [3:0]  sel;
    logic [31:0] data;
  } rf_wr_t;

  function automatic logic [31:0] sext16(input logic [15:0] v);
    return {{16{v[15]}}, v};
  endfunction

  function automatic logic [31:0] sext8(input logic [7:0] v);
    return {{24{v[7]}}, v};
  endfunction

endpackage

`default_nettype wire

### hdl/m68020_effective_address_unit.sv
// Path: the result passes through the input register, then the result register.
// Throughput: one item per cycle while rsp_ready takes each result; each item is one pass through the sequencer adder.
// The result register lets a new item enter while the previous result waits.
// Reset: synchronous; clears D/A registers, sequencer state (idle), and both valids.
// Top level of the 68020 effective address unit.
`default_nettype none

module m68020_effective_address_unit (
  input  wire logic            clk,
  input  wire logic            rst,
  input  wire logic            req_valid,
  output logic                 req_ready,
  input  wire m68ea_pkg::req_t req,
  output logic                 rsp_valid,
  input  wire logic            rsp_ready,
  output m68ea_pkg::rsp_t      rsp
);
  import m68ea_pkg::*;

  req_t        item;
  logic        item_full;
  logic        advance;
  rsp_t        result;
  rf_wr_t      wr;
  logic [3:0]  rd_sel;
  logic [31:0] rd_data;
  logic [15:0] ext_sel;
  logic [31:0] index;

  assign advance   = item_full && (!rsp_valid || rsp_ready);
  assign req_ready = !item_full || advance;

  // Hold the accepted item
  always_ff @(posedge clk) begin
    if (rst) begin
      item_full <= 1'b0;
    end else if (req_ready) begin
      item_full <= req_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (req_valid && req_ready) begin
      item <= req;
    end
  end

  m68ea_regfile u_regfile (
    .clk     (clk),
    .rst     (rst),
    .wr      (wr),
    .rd_sel  (rd_sel),
    .rd_data (rd_data)
  );

  m68ea_index u_index (
    .ext       (ext_sel),
    .reg_value (rd_data),
    .index     (index)
  );

  m68ea_seq u_seq (
    .clk     (clk),
    .rst     (rst),
    .advance (advance),
    .item    (item),
    .rd_data (rd_data),
    .index   (index),
    .rd_sel  (rd_sel),
    .ext_sel (ext_sel),
    .wr      (wr),
    .result  (result)
  );

  // Register the result until taken
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (advance) begin
      rsp_valid <= 1'b1;
    end else if (rsp_ready) begin
      rsp_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      rsp <= result;
    end
  end

endmodule

`default_nettype wire

### hdl/m68ea_regfile.sv
// D0-D7 and A0-A7 register file with one write port and one read port.
`default_nettype none

module m68ea_regfile (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire m68ea_pkg::rf_wr_t wr,
  input  wire logic [3:0]       rd_sel,
  output logic [31:0]           rd_data
);
  import m68ea_pkg::*;

  logic [31:0] regs [16];

  // Write one register; reset clears all
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 16; i++) begin
        regs[i] <= '0;
      end
    end else if (wr.en) begin
      regs[wr.sel] <= wr.data;
    end
  end

  assign rd_data = regs[rd_sel];

endmodule

`default_nettype wire

### hdl/m68ea_index.sv
// Index operand: word or long index register, sign extended and scaled.
`default_nettype none

module m68ea_index (
  input  wire logic [15:0] ext,
  input  wire logic [31:0] reg_value,
  output logic [31:0]      index
);
  import m68ea_pkg::*;

  logic [31:0] sized;

  // Take low word sign extended unless W/L selects long
  assign sized = ext[11] ? reg_value : sext16(reg_value[15:0]);
  // Scale by 1, 2, 4 or 8
  assign index = sized << ext[10:9];

endmodule

`default_nettype wire

### hdl/m68ea_seq.sv
// Address sequencer: phase, accumulator, extension word and PC state.
`default_nettype none

module m68ea_seq (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             advance,
  input  wire m68ea_pkg::req_t  item,
  input  wire logic [31:0]      rd_data,
  input  wire logic [31:0]      index,
  output logic [3:0]            rd_sel,
  output logic [15:0]           ext_sel,
  output m68ea_pkg::rf_wr_t     wr,
  output m68ea_pkg::rsp_t       result
);
  import m68ea_pkg::*;

  phase_t      phase, phase_next;
  logic [31:0] accum, accum_next;
  logic [15:0] ext_word, ext_word_next;
  logic [31:0] cur_pc, cur_pc_next;
  logic [15:0] hi_half, hi_half_next;

  logic [15:0] w;
  logic [31:0] pc_inc;
  logic [31:0] long_w;
  logic [3:0]  step;
  logic        ext_bad;
  logic        bd_add_idx;
  logic        bd_done;
  logic [31:0] bd_index;
  logic [31:0] ind_index;
  logic [31:0] bs_base;
  logic [31:0] acc_tmp;
  kind_t       kind;
  logic [31:0] addr;

  assign w      = item.word;
  assign pc_inc = cur_pc + 32'd2;
  assign long_w = {hi_half, w};

  // The word being decoded is the incoming one in the extension phase
  assign ext_sel = (phase == PH_EXT) ? w : ext_word;
  assign rd_sel  = (item.action == ACT_BEGIN) ? {1'b1, item.reg_req}
                                              : {ext_sel[15], ext_sel[14:12]};

  // Full format field checks
  assign ext_bad = (w[5:4] == DSZ_RSVD) || (!w[6] && w[2:0] == 3'd4) || (w[6] && w[2]);
  assign bd_add_idx = !ext_sel[2] && !ext_sel[6];
  assign bd_done    = (ext_sel[2:0] == 3'd0);
  assign bd_index   = bd_add_idx ? index : 32'd0;
  assign ind_index  = ext_word[2] ? index : 32'd0;
  assign bs_base    = w[7] ? 32'd0 : accum;

  // Post-increment / pre-decrement step
  always_comb begin
    case (item.size)
      SZ_BYTE: step = (item.reg_req == SP_REG) ? 4'd2 : 4'd1;
      SZ_WORD: step = 4'd2;
      SZ_LONG: step = 4'd4;
      SZ_QUAD: step = 4'd8;
      default: step = 4'd0;
    endcase
  end

  // Next phase
  always_comb begin
    phase_next = phase;
    case (item.action)
      ACT_BEGIN: begin
        case (item.mode)
          MODE_DISP:  phase_next = PH_D_W;
          MODE_INDEX: phase_next = PH_EXT;
          MODE_SPECIAL: begin
            case (item.reg_req)
              SPC_ABS_W:    phase_next = PH_D_W;
              SPC_ABS_L:    phase_next = PH_D_HI;
              SPC_PC_DISP:  phase_next = PH_D_W;
              SPC_PC_INDEX: phase_next = PH_EXT;
              default:      phase_next = PH_IDLE;
            endcase
          end
          default: phase_next = PH_IDLE;
        endcase
      end
      ACT_WORD: begin
        case (phase)
          PH_IDLE, PH_IND: phase_next = phase;
          PH_D_HI:  phase_next = PH_D_LO;
          PH_BD_HI: phase_next = PH_BD_LO;
          PH_OD_HI: phase_next = PH_OD_LO;
          PH_EXT: begin
            if (!w[8] || ext_bad) begin
              phase_next = PH_IDLE;
            end else if (w[5:4] == DSZ_NULL) begin
              phase_next = bd_done ? PH_IDLE : PH_IND;
            end else begin
              phase_next = (w[5:4] == DSZ_WORD) ? PH_BD_W : PH_BD_HI;
            end
          end
          PH_BD_W, PH_BD_LO: phase_next = bd_done ? PH_IDLE : PH_IND;
          default: phase_next = PH_IDLE;
        endcase
      end
      ACT_LONG: begin
        if (phase == PH_IND) begin
          case (ext_word[1:0])
            DSZ_WORD: phase_next = PH_OD_W;
            DSZ_LONG: phase_next = PH_OD_HI;
            default:  phase_next = PH_IDLE;
          endcase
        end
      end
      default: phase_next = phase;
    endcase
  end

  // Datapath and result
  always_comb begin
    accum_next    = accum;
    ext_word_next = ext_word;
    cur_pc_next   = cur_pc;
    hi_half_next  = hi_half;
    wr            = '0;
    kind          = K_ERROR;
    addr          = 32'd0;
    acc_tmp       = 32'd0;
    case (item.action)
      ACT_WRITE: begin
        wr.en   = 1'b1;
        wr.sel  = item.reg_select;
        wr.data = item.data;
        kind    = K_WRITE;
      end
      ACT_BEGIN: begin
        cur_pc_next = item.pc;
        kind        = K_WORD;
        addr        = item.pc;
        case (item.mode)
          MODE_AN_IND: begin
            accum_next = rd_data;
            kind       = K_READY;
            addr       = rd_data;
          end
          MODE_POSTINC: begin
            accum_next = rd_data;
            wr.en      = 1'b1;
            wr.sel     = {1'b1, item.reg_req};
            wr.data    = rd_data + {28'd0, step};
            kind       = K_READY;
            addr       = rd_data;
          end
          MODE_PREDEC: begin
            acc_tmp    = rd_data - {28'd0, step};
            accum_next = acc_tmp;
            wr.en      = 1'b1;
            wr.sel     = {1'b1, item.reg_req};
            wr.data    = acc_tmp;
            kind       = K_READY;
            addr       = acc_tmp;
          end
          MODE_DISP, MODE_INDEX: accum_next = rd_data;
          MODE_SPECIAL: begin
            case (item.reg_req)
              SPC_ABS_W, SPC_ABS_L:      accum_next = 32'd0;
              SPC_PC_DISP, SPC_PC_INDEX: accum_next = item.pc;
              default: begin
                kind = K_ERROR;
                addr = 32'd0;
              end
            endcase
          end
          default: begin
            kind = K_ERROR;
            addr = 32'd0;
          end
        endcase
      end
      ACT_WORD: begin
        if (phase != PH_IDLE && phase != PH_IND) begin
          cur_pc_next = pc_inc;
          case (phase)
            PH_D_W, PH_OD_W: begin
              acc_tmp    = accum + sext16(w);
              accum_next = acc_tmp;
              kind       = K_READY;
              addr       = acc_tmp;
            end
            PH_D_HI, PH_BD_HI, PH_OD_HI: begin
              hi_half_next = w;
              kind         = K_WORD;
              addr         = pc_inc;
            end
            PH_EXT: begin
              ext_word_next = w;
              if (!w[8]) begin
                // Brief format
                acc_tmp    = accum + sext8(w[7:0]) + index;
                accum_next = acc_tmp;
                kind       = K_READY;
                addr       = acc_tmp;
              end else if (ext_bad) begin
                kind = K_ERROR;
              end else if (w[5:4] == DSZ_NULL) begin
                acc_tmp    = bs_base + bd_index;
                accum_next = acc_tmp;
                kind       = bd_done ? K_READY : K_LONG;
                addr       = acc_tmp;
              end else begin
                accum_next = bs_base;
                kind       = K_WORD;
                addr       = pc_inc;
              end
            end
            PH_BD_W, PH_BD_LO: begin
              acc_tmp    = accum + ((phase == PH_BD_W) ? sext16(w) : long_w) + bd_index;
              accum_next = acc_tmp;
              kind       = bd_done ? K_READY : K_LONG;
              addr       = acc_tmp;
            end
            default: begin
              acc_tmp    = accum + long_w;
              accum_next = acc_tmp;
              kind       = K_READY;
              addr       = acc_tmp;
            end
          endcase
        end
      end
      ACT_LONG: begin
        if (phase == PH_IND) begin
          acc_tmp    = item.data + ind_index;
          accum_next = acc_tmp;
          if (ext_word[1:0] == DSZ_WORD || ext_word[1:0] == DSZ_LONG) begin
            kind = K_WORD;
            addr = cur_pc;
          end else begin
            kind = K_READY;
            addr = acc_tmp;
          end
        end
      end
      default: kind = K_ERROR;
    endcase
    // Drop the register write unless the item advances this cycle
    if (!advance) begin
      wr.en = 1'b0;
    end
  end

  assign result.kind    = kind;
  assign result.address = addr & ADDR_MASK;
  assign result.pc_out  = cur_pc_next & ADDR_MASK;

  // Advance sequencer state once per item
  always_ff @(posedge clk) begin
    if (rst) begin
      phase    <= PH_IDLE;
      accum    <= '0;
      ext_word <= '0;
      cur_pc   <= '0;
      hi_half  <= '0;
    end else if (advance) begin
      phase    <= phase_next;
      accum    <= accum_next;
      ext_word <= ext_word_next;
      cur_pc   <= cur_pc_next;
      hi_half  <= hi_half_next;
    end
  end

endmodule

`default_nettype wire

### bench/m68020_effective_address_unit_tb.sv
// Self-checking testbench for the 68020 effective address unit.
`default_nettype none

module m68020_effective_address_unit_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import m68ea_pkg::*;

  localparam int CLK_PERIOD  = 8;
  localparam int CYCLE_LIMIT = 200000;
  localparam int RANDOM_ITEMS = 1650;

  // Tracks register files and sequencer state, and queues the replies due
  class ea_address_tracker;
    logic [31:0] dregs [8];
    logic [31:0] aregs [8];
    phase_t      phase;
    logic [31:0] accum;
    logic [31:0] cur_pc;
    logic [15:0] ext_word;
    logic [15:0] hi_half;
    rsp_t        awaited [$];
    int          failures;
    int          items;
    int          kind_count [5];

    function new();
      for (int i = 0; i < 8; i++) begin
        dregs[i] = '0;
        aregs[i] = '0;
      end
      phase    = PH_IDLE;
      accum    = '0;
      cur_pc   = '0;
      ext_word = '0;
      hi_half  = '0;
      failures = 0;
      items    = 0;
      for (int i = 0; i < 5; i++) kind_count[i] = 0;
    endfunction

    function rsp_t reply(kind_t k, logic [31:0] a);
      rsp_t r;
      r.kind    = k;
      r.address = a & ADDR_MASK;
      r.pc_out  = cur_pc & ADDR_MASK;
      return r;
    endfunction

    function rsp_t address_done();
      phase = PH_IDLE;
      return reply(K_READY, accum);
    endfunction

    function rsp_t sequence_error();
      phase = PH_IDLE;
      return reply(K_ERROR, '0);
    endfunction

    // Index register from the extension word, sign extended if word sized, then scaled
    function logic [31:0] index_term(logic [15:0] ext);
      logic [31:0] v;
      v = ext[15] ? aregs[ext[14:12]] : dregs[ext[14:12]];
      if (!ext[11]) v = {{16{v[15]}}, v[15:0]};
      return v << ext[10:9];
    endfunction

    function rsp_t after_base_disp();
      if (ext_word[2:0] < 3'd4 && !ext_word[6]) accum += index_term(ext_word);
      if (ext_word[2:0] == 3'd0) return address_done();
      phase = PH_IND;
      return reply(K_LONG, accum);
    endfunction

    function rsp_t after_indirect();
      case (ext_word[1:0])
        DSZ_WORD: begin
          phase = PH_OD_W;
          return reply(K_WORD, cur_pc);
        end
        DSZ_LONG: begin
          phase = PH_OD_HI;
          return reply(K_WORD, cur_pc);
        end
        default: return address_done();
      endcase
    endfunction

    function rsp_t take_extension(logic [15:0] w);
      ext_word = w;
      // Brief format: 8-bit displacement plus index
      if (!w[8]) begin
        accum += {{24{w[7]}}, w[7:0]} + index_term(w);
        return address_done();
      end
      // Reserved full format encodings
      if (w[5:4] == DSZ_RSVD || (!w[6] && w[2:0] == 3'd4) || (w[6] && w[2:0] >= 3'd4))
        return sequence_error();
      if (w[7]) accum = '0;
      if (w[5:4] == DSZ_NULL) return after_base_disp();
      phase = (w[5:4] == DSZ_WORD) ? PH_BD_W : PH_BD_HI;
      return reply(K_WORD, cur_pc);
    endfunction

    function rsp_t begin_address(logic [2:0] mode, logic [2:0] r, logic [2:0] size);
      logic [31:0] step;
      case (size)
        SZ_BYTE: step = (r == SP_REG) ? 32'd2 : 32'd1;
        SZ_WORD: step = 32'd2;
        SZ_LONG: step = 32'd4;
        SZ_QUAD: step = 32'd8;
        default: step = 32'd0;
      endcase
      phase = PH_IDLE;
      case (mode)
        MODE_AN_IND: begin
          accum = aregs[r];
          return address_done();
        end
        MODE_POSTINC: begin
          accum = aregs[r];
          aregs[r] += step;
          return address_done();
        end
        MODE_PREDEC: begin
          aregs[r] -= step;
          accum = aregs[r];
          return address_done();
        end
        MODE_DISP: begin
          accum = aregs[r];
          phase = PH_D_W;
        end
        MODE_INDEX: begin
          accum = aregs[r];
          phase = PH_EXT;
        end
        MODE_SPECIAL: begin
          case (r)
            SPC_ABS_W: begin
              accum = '0;
              phase = PH_D_W;
            end
            SPC_ABS_L: begin
              accum = '0;
              phase = PH_D_HI;
            end
            SPC_PC_DISP: begin
              accum = cur_pc;
              phase = PH_D_W;
            end
            SPC_PC_INDEX: begin
              accum = cur_pc;
              phase = PH_EXT;
            end
            default: return sequence_error();
          endcase
        end
        default: return sequence_error();
      endcase
      return reply(K_WORD, cur_pc);
    endfunction

    function rsp_t take_word(logic [15:0] w);
      cur_pc += 32'd2;
      case (phase)
        PH_D_W, PH_OD_W: begin
          accum += {{16{w[15]}}, w};
          return address_done();
        end
        PH_D_HI, PH_BD_HI, PH_OD_HI: begin
          hi_half = w;
          phase   = phase_t'(phase + 4'd1);
          return reply(K_WORD, cur_pc);
        end
        PH_EXT: return take_extension(w);
        PH_BD_W: begin
          accum += {{16{w[15]}}, w};
          return after_base_disp();
        end
        PH_BD_LO: begin
          accum += {hi_half, w};
          return after_base_disp();
        end
        default: begin
          accum += {hi_half, w};
          return address_done();
        end
      endcase
    endfunction

    function rsp_t step_sequencer(req_t it);
      case (it.action)
        ACT_WRITE: begin
          if (it.reg_select[3]) aregs[it.reg_select[2:0]] = it.data;
          else dregs[it.reg_select[2:0]] = it.data;
          return reply(K_WRITE, '0);
        end
        ACT_BEGIN: begin
          cur_pc = it.pc;
          return begin_address(it.mode, it.reg_req, it.size);
        end
        ACT_WORD: begin
          // A word nobody asked for changes nothing
          if (phase == PH_IDLE || phase == PH_IND) return reply(K_ERROR, '0);
          return take_word(it.word);
        end
        default: begin
          if (phase != PH_IND) return reply(K_ERROR, '0);
          accum = it.data;
          if (ext_word[2:0] >= 3'd4) accum += index_term(ext_word);
          return after_indirect();
        end
      endcase
    endfunction

    function void take_request(req_t it);
      rsp_t r;
      r = step_sequencer(it);
      items++;
      kind_count[r.kind]++;
      awaited.push_back(r);
    endfunction

    function void check_response(rsp_t got);
      rsp_t want;
      if (awaited.size() == 0) begin
        failures++;
        if (failures <= 10)
          $display("unexpected result: kind %0d address %h pc %h",
                   got.kind, got.address, got.pc_out);
        return;
      end
      want = awaited.pop_front();
      if (got.kind !== want.kind || got.address !== want.address ||
          got.pc_out !== want.pc_out) begin
        failures++;
        if (failures <= 10)
          $display("mismatch: kind %0d/%0d address %h/%h pc %h/%h (expected/actual)",
                   want.kind, got.kind, want.address, got.address,
                   want.pc_out, got.pc_out);
      end
    endfunction
  endclass

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic req_valid;
  logic req_ready;
  req_t req;
  logic rsp_valid;
  logic rsp_ready = 1'b0;
  rsp_t rsp;

  int send_idle_pct = 0;
  int recv_stall_pct = 0;
  int cycle_count = 0;

  ea_address_tracker tracker = new();

  m68020_effective_address_unit u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .req       (req),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .rsp       (rsp)
  );

  always #(CLK_PERIOD / 2) clk = ~clk;

  // Check each accepted result, then pick the next ready level
  always @(posedge clk) begin
    if (!rst && rsp_valid && rsp_ready) tracker.check_response(rsp);
    rsp_ready <= ($urandom_range(0, 99) >= recv_stall_pct);
  end

  // Give up if the run stalls
  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("TEST FAILED");
    $finish;
  end

  // Fill every field at random, so don't-care bits toggle too
  function automatic req_t random_fill();
    req_t it;
    it.action     = action_t'($urandom_range(0, 3));
    it.reg_select = 4'($urandom);
    it.data       = $urandom;
    it.word       = 16'($urandom);
    it.mode       = 3'($urandom);
    it.reg_req    = 3'($urandom);
    it.size       = 3'($urandom_range(0, 4));
    it.pc         = $urandom;
    return it;
  endfunction

  function automatic req_t op_write(logic [3:0] sel, logic [31:0] d);
    req_t it;
    it = random_fill();
    it.action     = ACT_WRITE;
    it.reg_select = sel;
    it.data       = d;
    return it;
  endfunction

  function automatic req_t op_begin(logic [2:0] m, logic [2:0] r, logic [2:0] s,
                                    logic [31:0] p);
    req_t it;
    it = random_fill();
    it.action  = ACT_BEGIN;
    it.mode    = m;
    it.reg_req = r;
    it.size    = s;
    it.pc      = p;
    return it;
  endfunction

  function automatic req_t op_word(logic [15:0] w);
    req_t it;
    it = random_fill();
    it.action = ACT_WORD;
    it.word   = w;
    return it;
  endfunction

  function automatic req_t op_long(logic [31:0] d);
    req_t it;
    it = random_fill();
    it.action = ACT_LONG;
    it.data   = d;
    return it;
  endfunction

  function automatic logic [31:0] random_value();
    logic [15:0] h;
    h = 16'($urandom);
    case ($urandom_range(0, 3))
      0: return {{16{h[15]}}, h};
      1: return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'h0000_0000;
      default: return $urandom;
    endcase
  endfunction

  // Mostly well-formed full formats, some brief, a few arbitrary
  function automatic logic [15:0] random_extension();
    logic [15:0] w;
    int pick;
    w    = 16'($urandom);
    pick = $urandom_range(0, 99);
    if (pick < 35) begin
      w[8] = 1'b0;
    end else if (pick < 92) begin
      w[8]   = 1'b1;
      w[5:4] = 2'($urandom_range(1, 3));
      if (w[6]) w[2:0] = 3'($urandom_range(0, 3));
      else if ($urandom_range(0, 1)) w[2:0] = 3'($urandom_range(0, 3));
      else w[2:0] = 3'($urandom_range(5, 7));
    end
    return w;
  endfunction

  // Follow the sequence the block is in, with some noise and abandoned sequences
  function automatic req_t next_random_req();
    req_t it;
    int pick;
    logic [2:0] m;
    logic [2:0] r;
    logic [31:0] p;
    pick = $urandom_range(0, 99);
    if (pick < 6) return random_fill();
    if (pick < 12) return op_write(4'($urandom), random_value());
    if (tracker.phase == PH_IDLE || pick < 15) begin
      if ($urandom_range(0, 9) < 2) m = 3'($urandom);
      else m = 3'($urandom_range(2, 7));
      if (m >= MODE_DISP) m = 3'($urandom_range(5, 7));
      r = 3'($urandom);
      if (m == MODE_SPECIAL && $urandom_range(0, 9) != 0) r = 3'($urandom_range(0, 3));
      p = $urandom_range(0, 3) == 0 ? 32'hFFFF_FFF0 + $urandom_range(0, 15) : $urandom;
      return op_begin(m, r, 3'($urandom_range(0, 4)), p);
    end
    if (tracker.phase == PH_IND) return op_long(random_value());
    if (tracker.phase == PH_EXT) return op_word(random_extension());
    it = op_word(16'($urandom));
    return it;
  endfunction

  task automatic send_req(input req_t it);
    int gap;
    req       <= it;
    req_valid <= 1'b1;
    @(posedge clk);
    while (!req_ready) @(posedge clk);
    tracker.take_request(it);
    gap = 0;
    while ($urandom_range(0, 99) < send_idle_pct) gap++;
    if (gap > 0) begin
      req_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // Hold the sender until every awaited result is back
  task automatic drain();
    req_valid <= 1'b0;
    @(posedge clk);
    while (tracker.awaited.size() != 0) @(posedge clk);
  endtask

  initial begin
    int idle_set [4];
    int stall_set [4];
    req_valid = 1'b0;
    req       = '0;
    idle_set  = '{0, 62, 0, 6};
    stall_set = '{0, 0, 62, 6};

    // Hold reset, then release
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: register extremes and most addressing modes
    send_req(op_write(4'd10, 32'h0000_1000));
    send_req(op_write(4'd3, 32'hFFFF_FFFF));
    send_req(op_write(4'd15, 32'h8000_0000));
    send_req(op_begin(MODE_AN_IND, 3'd2, SZ_LONG, 32'h0));
    // Byte steps on the stack pointer go by two
    send_req(op_begin(MODE_POSTINC, SP_REG, SZ_BYTE, 32'h0));
    send_req(op_begin(MODE_PREDEC, SP_REG, SZ_BYTE, 32'h0));
    // No size leaves An alone; a quad predecrement steps by eight
    send_req(op_begin(MODE_POSTINC, 3'd2, 3'd4, 32'h0));
    send_req(op_begin(MODE_PREDEC, 3'd2, SZ_QUAD, 32'h0));
    // Register direct and immediate are refused
    send_req(op_begin(3'd0, 3'd0, SZ_WORD, 32'h0));
    send_req(op_begin(MODE_SPECIAL, 3'd4, SZ_LONG, 32'h0));
    // Word while idle
    send_req(op_word(16'hFFFF));
    send_req(op_begin(MODE_DISP, 3'd2, SZ_WORD, 32'hFFFF_FFFE));
    // Long while a word is wanted changes nothing
    send_req(op_long(32'hFFFF_FFFF));
    send_req(op_word(16'h8000));
    // Absolute long with a register write in the middle
    send_req(op_begin(MODE_SPECIAL, SPC_ABS_L, SZ_LONG, 32'h0));
    send_req(op_word(16'hFFFF));
    send_req(op_write(4'd3, 32'h7FFF_FFFF));
    send_req(op_word(16'h0000));
    // Brief index: D3.L scaled by 8, displacement -128
    send_req(op_begin(MODE_INDEX, 3'd2, SZ_LONG, 32'h0000_0200));
    send_req(op_word(16'h3E80));
    // Full format from PC, then abandon it with a new begin
    send_req(op_begin(MODE_SPECIAL, SPC_PC_INDEX, SZ_LONG, 32'h0000_0100));
    send_req(op_word(16'hF333));
    send_req(op_begin(MODE_INDEX, 3'd1, SZ_BYTE, 32'h0000_0400));
    // Reserved base displacement size, then a stray long
    send_req(op_word(16'h0100));
    send_req(op_long(32'h1234_5678));
    drain();

    // Random sequences under each idling pattern
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct  = idle_set[ph];
      recv_stall_pct = stall_set[ph];
      for (int n = 0; n < RANDOM_ITEMS / 4; n++) send_req(next_random_req());
      drain();
    end

    recv_stall_pct = 0;
    repeat (10) @(posedge clk);

    $display("%0d items: %0d addresses, %0d word and %0d long requests, %0d errors, %0d writes",
             tracker.items, tracker.kind_count[K_READY], tracker.kind_count[K_WORD],
             tracker.kind_count[K_LONG], tracker.kind_count[K_ERROR],
             tracker.kind_count[K_WRITE]);
    $display("%0d mismatches, %0d results outstanding", tracker.failures,
             tracker.awaited.size());
    if (tracker.failures == 0 && tracker.awaited.size() == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule

`default_nettype wire
